// ===== rtl/ask_pkg.sv =====
// Shared types, constants and the arctangent table for the anchor station-keeping block.
// No dependencies; used by every RTL module of the block.
package ask_pkg;

  localparam int CordicStepsDef = 16;
  localparam int XW = 44;  // CORDIC x/y width, signed
  localparam int ZW = 28;  // CORDIC angle width, signed, 2^-24 rad
  localparam int CfgW = 30;
  localparam int CfgIdxW = 3;

  localparam logic signed [ZW-1:0] PiFine = 28'sd52707179;
  localparam logic [21:0] InvGainQ22 = 22'd2547003;
  localparam logic signed [17:0] PiOut = 18'sd25736;
  localparam logic signed [17:0] TwoPiOut = 18'sd51472;

  typedef enum logic [CfgIdxW-1:0] {
    REG_GAIN      = 3'd0,
    REG_RADIUS    = 3'd1,
    REG_FLOOR     = 3'd2,
    REG_CEILING   = 3'd3,
    REG_SAFETY    = 3'd4,
    REG_TOLERANCE = 3'd5
  } ask_reg_e;

  // Side data that rides along the pipeline untouched by the CORDIC
  typedef struct packed {
    logic signed [15:0] vhead;
    logic [23:0]        tdep;
    logic [19:0]        talt;
    logic               alt;
    logic signed [24:0] marker;
    logic               zero;
  } ask_aux_t;

  typedef struct packed {
    logic [15:0]        gain;
    logic [16:0]        radius;
    logic signed [13:0] floor_v;
    logic signed [13:0] ceil_v;
    logic [29:0]        safety;
    logic [14:0]        tol;
  } ask_cfg_t;

  typedef struct packed {
    logic signed [13:0] surge;
    logic signed [15:0] heading;
    logic [23:0]        depth;
    logic [19:0]        altitude;
    logic               alt_mode;
    logic [23:0]        setpoint;
    logic [31:0]        range;
    logic signed [24:0] marker;
  } ask_res_t;

  // atan(2^-i) in units of 2^-24 rad, rounded
  function automatic logic signed [ZW-1:0] atan_val(input int i);
    logic signed [ZW-1:0] v;
    case (i)
      0: v = 28'sd13176795;
      1: v = 28'sd7778716;
      2: v = 28'sd4110060;
      3: v = 28'sd2086331;
      4: v = 28'sd1047214;
      5: v = 28'sd524117;
      6: v = 28'sd262123;
      7: v = 28'sd131069;
      8: v = 28'sd65536;
      9: v = 28'sd32768;
      10: v = 28'sd16384;
      11: v = 28'sd8192;
      12: v = 28'sd4096;
      13: v = 28'sd2048;
      14: v = 28'sd1024;
      15: v = 28'sd512;
      16: v = 28'sd256;
      17: v = 28'sd128;
      18: v = 28'sd64;
      19: v = 28'sd32;
      20: v = 28'sd16;
      21: v = 28'sd8;
      22: v = 28'sd4;
      23: v = 28'sd2;
      24: v = 28'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/ask_cordic_stage.sv =====
// One registered CORDIC vectoring iteration with a fixed shift.
// Depends on ask_pkg.
module ask_cordic_stage import ask_pkg::*; #(
  parameter int Shift = 0
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [XW-1:0] y_i,
  input  logic signed [ZW-1:0] z_i,
  input  ask_aux_t             aux_i,
  output logic                 valid_o,
  output logic signed [XW-1:0] x_o,
  output logic signed [XW-1:0] y_o,
  output logic signed [ZW-1:0] z_o,
  output ask_aux_t             aux_o
);

  logic signed [XW-1:0] x_d, y_d, xs, ys;
  logic signed [ZW-1:0] z_d;
  logic valid_q;

  // Rotate toward y = 0
  always_comb begin
    xs = x_i >>> Shift;
    ys = y_i >>> Shift;
    if (!y_i[XW-1]) begin
      x_d = x_i + ys;
      y_d = y_i - xs;
      z_d = z_i + atan_val(Shift);
    end else begin
      x_d = x_i - ys;
      y_d = y_i + xs;
      z_d = z_i - atan_val(Shift);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (en_i) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      x_o   <= x_d;
      y_o   <= y_d;
      z_o   <= z_d;
      aux_o <= aux_i;
    end
  end

  assign valid_o = valid_q;

endmodule

// ===== rtl/ask_post.sv =====
// Post-CORDIC stages: gain correction, bearing rounding, surge law and limits.
// Depends on ask_pkg.
module ask_post import ask_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  logic                 valid_i,
  input  logic signed [XW-1:0] x_i,
  input  logic signed [ZW-1:0] z_i,
  input  ask_aux_t             aux_i,
  input  ask_cfg_t             cfg_i,
  output logic                 valid_o,
  output ask_res_t             res_o
);

  logic [3:0] valid_q;

  // Stage A: split distance multiply
  logic [42:0] ph_q, pl_q;
  logic signed [ZW-1:0] za_q;
  ask_aux_t auxa_q;

  // Stage B: distance and bearing
  logic [33:0] dist_q;
  logic signed [16:0] yaw_q;
  ask_aux_t auxb_q;

  // Stage C: surge product and heading error check
  logic signed [52:0] p_q;
  logic errbig_q;
  logic [33:0] distc_q;
  logic signed [16:0] yawc_q;
  ask_aux_t auxc_q;

  logic [64:0] sum_b;
  logic signed [ZW-1:0] zr_b;
  logic signed [16:0] yr_b, yaw_b;
  logic signed [35:0] diff_c;
  logic signed [17:0] err_c;
  logic [17:0] abs_c;
  logic signed [44:0] sw_d;
  logic signed [13:0] surge_d;

  always_comb begin
    sum_b = ({22'd0, ph_q} << 21) + {22'd0, pl_q} + (65'd1 << 29);
    zr_b  = za_q + ZW'(1024);
    yr_b  = 17'(zr_b >>> 11);
    yaw_b = yr_b;
    if (yr_b > 17'(PiOut)) yaw_b = yr_b - 17'(TwoPiOut);
    if (yaw_b < -17'(PiOut)) yaw_b = yaw_b + 17'(TwoPiOut);

    diff_c = $signed({2'b00, dist_q}) - $signed({19'd0, cfg_i.radius});
    err_c  = 18'(yaw_q) - 18'(auxb_q.vhead);
    if (err_c > PiOut) err_c = err_c - TwoPiOut;
    if (err_c < -PiOut) err_c = err_c + TwoPiOut;
    abs_c = err_c[17] ? 18'(-err_c) : 18'(err_c);

    sw_d = 45'((p_q + 53'sd128) >>> 8);
    if (sw_d > 45'(cfg_i.ceil_v)) sw_d = 45'(cfg_i.ceil_v);
    if (sw_d < 45'(cfg_i.floor_v)) sw_d = 45'(cfg_i.floor_v);
    surge_d = 14'(sw_d);
    if (errbig_q) surge_d = '0;
    if (distc_q > {4'd0, cfg_i.safety}) surge_d = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (en_i) begin
      valid_q <= {valid_q[2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      ph_q   <= 43'(x_i[41:21]) * 43'(InvGainQ22);
      pl_q   <= 43'(x_i[20:0]) * 43'(InvGainQ22);
      za_q   <= z_i;
      auxa_q <= aux_i;

      dist_q <= auxa_q.zero ? '0 : sum_b[63:30];
      yaw_q  <= auxa_q.zero ? '0 : yaw_b;
      auxb_q <= auxa_q;

      p_q      <= $signed({1'b0, cfg_i.gain}) * diff_c;
      errbig_q <= abs_c > {3'd0, cfg_i.tol};
      distc_q  <= dist_q;
      yawc_q   <= yaw_q;
      auxc_q   <= auxb_q;

      res_o.surge    <= surge_d;
      res_o.heading  <= (distc_q > {4'd0, cfg_i.safety}) ? '0 : 16'(yawc_q);
      res_o.depth    <= auxc_q.tdep;
      res_o.altitude <= auxc_q.talt;
      res_o.alt_mode <= auxc_q.alt;
      res_o.setpoint <= auxc_q.alt ? {4'd0, auxc_q.talt} : auxc_q.tdep;
      res_o.range    <= distc_q[31:0];
      res_o.marker   <= auxc_q.marker;
    end
  end

  assign valid_o = valid_q[3];

endmodule

// ===== rtl/anchor_station_keeping_control.sv =====
// Top level of the anchor station-keeping controller: input stage, CORDIC chain, post stages.
// Depends on ask_pkg, ask_cordic_stage and ask_post.

// Takes one navigation beat per clock while the output is not stalled and returns one command
// beat per input beat, in order. Stages: one input stage, one register per CORDIC iteration,
// and four stages for the distance multiply, bearing, surge product and limits. The whole
// pipeline holds while a result waits on m_axis_tready; s_axis_tready is low only then.
// Configuration writes go straight to the registers and should be made while idle.
module anchor_station_keeping_control import ask_pkg::*; #(
  parameter int CORDIC_STEPS = CordicStepsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgW-1:0]     cfg_data_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // vehicle_north, vehicle_east, vehicle_depth, vehicle_altitude, vehicle_heading,
  // target_north, target_east, target_depth, target_altitude, 4 zero bits
  input  logic [231:0]        s_axis_tdata,
  input  logic                s_axis_tuser,   // use_altitude
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // surge_command, heading_command, depth_out, altitude_out, depth_setpoint,
  // range_to_target, marker_end_depth, 5 zero bits
  output logic [159:0]        m_axis_tdata,
  output logic                m_axis_tuser    // altitude_mode_out
);

  ask_cfg_t cfg_q;
  logic en;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.gain    <= 16'd256;
      cfg_q.radius  <= 17'd2000;
      cfg_q.floor_v <= -14'sd500;
      cfg_q.ceil_v  <= 14'sd500;
      cfg_q.safety  <= 30'd50000;
      cfg_q.tol     <= 15'd4289;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_GAIN:      cfg_q.gain    <= cfg_data_i[15:0];
        REG_RADIUS:    cfg_q.radius  <= cfg_data_i[16:0];
        REG_FLOOR:     cfg_q.floor_v <= cfg_data_i[13:0];
        REG_CEILING:   cfg_q.ceil_v  <= cfg_data_i[13:0];
        REG_SAFETY:    cfg_q.safety  <= cfg_data_i[29:0];
        REG_TOLERANCE: cfg_q.tol     <= cfg_data_i[14:0];
        default: ;
      endcase
    end
  end

  assign en = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = en;

  // Input stage: offsets, prescale, half-plane fold, marker depth
  logic signed [30:0] vn, ve, tn, te;
  logic signed [31:0] dn, de;
  logic signed [XW-1:0] x0, y0;
  logic signed [ZW-1:0] z0;
  logic signed [25:0] mk;
  ask_aux_t aux0;

  always_comb begin
    vn = s_axis_tdata[30:0];
    ve = s_axis_tdata[61:31];
    tn = s_axis_tdata[152:122];
    te = s_axis_tdata[183:153];
    dn = 32'(tn) - 32'(vn);
    de = 32'(te) - 32'(ve);
    x0 = XW'(dn) <<< 8;
    y0 = XW'(de) <<< 8;
    z0 = '0;
    if (x0[XW-1]) begin
      z0 = y0[XW-1] ? -PiFine : PiFine;
      x0 = -x0;
      y0 = -y0;
    end
    if (s_axis_tuser) begin
      mk = $signed({2'b00, s_axis_tdata[85:62]}) + $signed({6'd0, s_axis_tdata[105:86]})
         - $signed({6'd0, s_axis_tdata[227:208]});
    end else begin
      mk = $signed({2'b00, s_axis_tdata[207:184]});
    end
    if (mk > 26'sd16777215) mk = 26'sd16777215;
    if (mk < -26'sd16777216) mk = -26'sd16777216;
    aux0.vhead  = s_axis_tdata[121:106];
    aux0.tdep   = s_axis_tdata[207:184];
    aux0.talt   = s_axis_tdata[227:208];
    aux0.alt    = s_axis_tuser;
    aux0.marker = 25'(mk);
    aux0.zero   = (dn == '0) && (de == '0);
  end

  logic                 v_s [CORDIC_STEPS+1];
  logic signed [XW-1:0] x_s [CORDIC_STEPS+1];
  logic signed [XW-1:0] y_s [CORDIC_STEPS+1];
  logic signed [ZW-1:0] z_s [CORDIC_STEPS+1];
  ask_aux_t             a_s [CORDIC_STEPS+1];
  logic                 v0_q;
  logic signed [XW-1:0] x0_q, y0_q;
  logic signed [ZW-1:0] z0_q;
  ask_aux_t             a0_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v0_q <= 1'b0;
    end else if (en) begin
      v0_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      x0_q <= x0;
      y0_q <= y0;
      z0_q <= z0;
      a0_q <= aux0;
    end
  end

  assign v_s[0] = v0_q;
  assign x_s[0] = x0_q;
  assign y_s[0] = y0_q;
  assign z_s[0] = z0_q;
  assign a_s[0] = a0_q;

  // CORDIC chain, one register per iteration
  for (genvar g = 0; g < CORDIC_STEPS; g++) begin : g_cordic
    ask_cordic_stage #(.Shift(g)) u_stage (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .en_i   (en),
      .valid_i(v_s[g]),
      .x_i    (x_s[g]),
      .y_i    (y_s[g]),
      .z_i    (z_s[g]),
      .aux_i  (a_s[g]),
      .valid_o(v_s[g+1]),
      .x_o    (x_s[g+1]),
      .y_o    (y_s[g+1]),
      .z_o    (z_s[g+1]),
      .aux_o  (a_s[g+1])
    );
  end

  ask_res_t res;

  ask_post u_post (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .valid_i(v_s[CORDIC_STEPS]),
    .x_i    (x_s[CORDIC_STEPS]),
    .z_i    (z_s[CORDIC_STEPS]),
    .aux_i  (a_s[CORDIC_STEPS]),
    .cfg_i  (cfg_q),
    .valid_o(m_axis_tvalid),
    .res_o  (res)
  );

  assign m_axis_tdata = {5'd0, res.marker, res.range, res.setpoint, res.altitude,
                         res.depth, res.heading, res.surge};
  assign m_axis_tuser = res.alt_mode;

  // Checks
  a_ready_follows_out : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready == (!m_axis_tvalid || m_axis_tready))
    else $error("input ready does not follow output slot");

  a_hold_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("result changed under stall");

  a_setpoint_mode : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tuser) |-> (m_axis_tdata[97:74] == m_axis_tdata[53:30]))
    else $error("depth setpoint differs from depth in depth mode");

  a_heading_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> ($signed(m_axis_tdata[29:14]) <= 16'sd25736 &&
                       $signed(m_axis_tdata[29:14]) >= -16'sd25736))
    else $error("heading command out of range");

endmodule

// ===== sim/anchor_station_keeping_checker.sv =====
`timescale 1ns / 1ps
// Checker for the anchor station-keeping block: predicts each command beat from the
// navigation beats and compares. Depends on ask_pkg for config indexes, widths and the CORDIC step count.
module anchor_station_keeping_checker import ask_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [CfgW-1:0]    cfg_data_i,
  input  logic               s_axis_tvalid,
  input  logic               s_axis_tready,
  input  logic [231:0]       s_axis_tdata,
  input  logic               s_axis_tuser,
  input  logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  input  logic [159:0]       m_axis_tdata,
  input  logic               m_axis_tuser,
  output int                 fail_count_o,
  output int                 pending_o
);

  typedef struct {
    longint surge, heading, depth, altitude, alt_mode, setpoint, range, marker;
  } cmd_t;

  cmd_t cmd_q[$];

  longint k_gain, k_radius, k_floor, k_ceil, k_safety, k_tol;

  localparam longint AtanTab[25] = '{13176795, 7778716, 4110060, 2086331, 1047214,
    524117, 262123, 131069, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2, 1};

  function automatic longint sx(longint v, int w);
    longint m;
    m = (longint'(1) << w) - 1;
    v = v & m;
    if (v[w-1]) return v | ~m;
    return v;
  endfunction

  // floor division by 2^s (>>> on a signed longint floors)
  function automatic longint fl_shr(longint v, int s);
    return v >>> s;
  endfunction

  function automatic cmd_t predict_command(logic [231:0] d, logic alt);
    cmd_t c;
    longint vn, ve, vdep, valt, vhead, tn, te, tdep, talt;
    longint x, y, z, xs, ys, yaw, err, surge, mk, rng;
    vn = sx(d[30:0], 31);
    ve = sx(d[61:31], 31);
    vdep = d[85:62];
    valt = d[105:86];
    vhead = sx(d[121:106], 16);
    tn = sx(d[152:122], 31);
    te = sx(d[183:153], 31);
    tdep = d[207:184];
    talt = d[227:208];
    z = 0;
    if (tn == vn && te == ve) begin
      rng = 0;
      yaw = 0;
    end else begin
      x = (tn - vn) * 256;
      y = (te - ve) * 256;
      if (x < 0) begin
        z = (y >= 0) ? 52707179 : -52707179;
        x = -x;
        y = -y;
      end
      for (int i = 0; i < CordicStepsDef; i++) begin
        xs = fl_shr(x, i);
        ys = fl_shr(y, i);
        if (y >= 0) begin
          x += ys; y -= xs; z += (i < 25) ? AtanTab[i] : 0;
        end else begin
          x -= ys; y += xs; z -= (i < 25) ? AtanTab[i] : 0;
        end
      end
      rng = longint'((64'(x) * 64'd2547003 + (64'd1 << 29)) >> 30);
      yaw = fl_shr(z + 1024, 11);
      if (yaw > 25736) yaw -= 51472;
      if (yaw < -25736) yaw += 51472;
    end
    surge = fl_shr(k_gain * (rng - k_radius) + 128, 8);
    if (surge > k_ceil) surge = k_ceil;
    if (surge < k_floor) surge = k_floor;
    err = yaw - vhead;
    while (err > 25736) err -= 51472;
    while (err < -25736) err += 51472;
    if (err < 0) err = -err;
    if (err > k_tol) surge = 0;
    if (rng > k_safety) begin
      surge = 0;
      yaw = 0;
    end
    mk = alt ? vdep + valt - talt : tdep;
    if (mk > 16777215) mk = 16777215;
    if (mk < -16777216) mk = -16777216;
    c.surge = surge & 14'h3fff;
    c.heading = yaw & 16'hffff;
    c.depth = tdep;
    c.altitude = talt;
    c.alt_mode = alt;
    c.setpoint = alt ? talt : tdep;
    c.range = rng & 32'hffffffff;
    c.marker = mk & 25'h1ffffff;
    return c;
  endfunction

  task automatic report_mismatch(string field, longint got, longint want);
    $display("mismatch %s: got %0d expected %0d at %0t", field, got, want, $time);
    fail_count_o++;
  endtask

  assign pending_o = cmd_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    cmd_t w;
    if (!rst_ni) begin
      k_gain = 256; k_radius = 2000; k_floor = -500; k_ceil = 500;
      k_safety = 50000; k_tol = 4289;
      fail_count_o = 0;
      cmd_q.delete();
    end else begin
      // result beat against the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (cmd_q.size() == 0) begin
          report_mismatch("unexpected beat", 0, 0);
        end else begin
          w = cmd_q.pop_front();
          if (m_axis_tdata[13:0] != w.surge) report_mismatch("surge", m_axis_tdata[13:0], w.surge);
          if (m_axis_tdata[29:14] != w.heading)
            report_mismatch("heading", m_axis_tdata[29:14], w.heading);
          if (m_axis_tdata[53:30] != w.depth) report_mismatch("depth", m_axis_tdata[53:30], w.depth);
          if (m_axis_tdata[73:54] != w.altitude)
            report_mismatch("altitude", m_axis_tdata[73:54], w.altitude);
          if (m_axis_tuser != w.alt_mode) report_mismatch("alt_mode", m_axis_tuser, w.alt_mode);
          if (m_axis_tdata[97:74] != w.setpoint)
            report_mismatch("setpoint", m_axis_tdata[97:74], w.setpoint);
          if (m_axis_tdata[129:98] != w.range) report_mismatch("range", m_axis_tdata[129:98], w.range);
          if (m_axis_tdata[154:130] != w.marker)
            report_mismatch("marker", m_axis_tdata[154:130], w.marker);
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        cmd_q.insert(cmd_q.size(), predict_command(s_axis_tdata, s_axis_tuser));
      // register writes
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_GAIN:      k_gain = cfg_data_i[15:0];
          REG_RADIUS:    k_radius = cfg_data_i[16:0];
          REG_FLOOR:     k_floor = sx(cfg_data_i[13:0], 14);
          REG_CEILING:   k_ceil = sx(cfg_data_i[13:0], 14);
          REG_SAFETY:    k_safety = cfg_data_i[29:0];
          REG_TOLERANCE: k_tol = cfg_data_i[14:0];
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Top of the anchor station-keeping testbench: clock, reset, stimulus and verdict.
// Depends on ask_pkg, the block and anchor_station_keeping_checker.
module testbench;
  import ask_pkg::*;

  localparam int Latency = CordicStepsDef + 5;
  localparam int CycleLimit = 400000;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgW-1:0]    cfg_data_i = '0;
  logic               s_axis_tvalid = 1'b0;
  logic               s_axis_tready;
  logic [231:0]       s_axis_tdata = '0;
  logic               s_axis_tuser = 1'b0;
  logic               m_axis_tvalid;
  logic               m_axis_tready = 1'b0;
  logic [159:0]       m_axis_tdata;
  logic               m_axis_tuser;
  int                 fail_count;
  int                 pending;
  int                 cycles = 0;
  bit                 sink_calm = 0;

  always #1 clk_i = ~clk_i;

  anchor_station_keeping_control DUT (.*);

  anchor_station_keeping_checker checker_i (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .s_axis_tvalid, .s_axis_tready,
    .s_axis_tdata, .s_axis_tuser, .m_axis_tvalid, .m_axis_tready, .m_axis_tdata,
    .m_axis_tuser, .fail_count_o(fail_count), .pending_o(pending)
  );

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("** anchor_station_keeping_control: FAILED **");
      $finish;
    end
  end

  // sink stalls in bursts
  initial begin
    int n;
    forever begin
      n = $urandom_range(1, 8);
      repeat (n) @(posedge clk_i) m_axis_tready <= sink_calm || ($urandom_range(0, 2) != 0);
      if (!sink_calm && $urandom_range(0, 3) == 0) begin
        n = $urandom_range(1, 8);
        repeat (n) @(posedge clk_i) m_axis_tready <= 1'b0;
      end
    end
  end

  function automatic longint pick_pos();
    case ($urandom_range(0, 5))
      0: return -1000000000;
      1: return 1000000000;
      2: return longint'($urandom_range(0, 2000000000)) - 1000000000;
      default: return longint'($urandom_range(0, 120000)) - 60000;
    endcase
  endfunction

  task automatic write_reg(ask_reg_e idx, longint val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= CfgW'(val);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // drop valid, wait for all predictions to drain, then the pipeline depth
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (Latency + 4) @(posedge clk_i);
  endtask

  // one navigation beat; fields in tdata order; valid stays up for the next beat
  task automatic send_nav(longint vn, longint ve, longint vdep, longint valt, longint vhead,
                          longint tn, longint te, longint tdep, longint talt, bit alt,
                          bit gaps);
    int n;
    if (gaps && $urandom_range(0, 3) == 0) begin
      n = $urandom_range(1, 8);
      s_axis_tvalid <= 1'b0;
      repeat (n) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {4'b0, 20'(talt), 24'(tdep), 31'(te), 31'(tn), 16'(vhead), 20'(valt),
                     24'(vdep), 31'(ve), 31'(vn)};
    s_axis_tuser <= alt;
    do @(posedge clk_i); while (!s_axis_tready);
  endtask

  task automatic random_nav(bit gaps);
    longint vn, ve, r;
    vn = pick_pos();
    ve = pick_pos();
    r = $urandom_range(0, 3) == 0 ? 1000000000 : 60000;
    send_nav(vn, ve, $urandom_range(0, 3) == 0 ? 10000000 : $urandom_range(0, 10000000),
             $urandom_range(0, 1000000), longint'($urandom_range(0, 51472)) - 25736,
             $urandom_range(0, 1) ? pick_pos() : vn + longint'($urandom_range(0, 2 * r)) - r,
             $urandom_range(0, 1) ? pick_pos() : ve + longint'($urandom_range(0, 2 * r)) - r,
             $urandom_range(0, 10000000), $urandom_range(0, 3) == 0 ? 1000000 :
             $urandom_range(0, 1000000), $urandom_range(0, 1), gaps);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    // directed: zero offset, axes, extremes, both modes
    send_nav(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0);
    send_nav(0, 0, 10000000, 1000000, 25736, 0, 0, 10000000, 1000000, 1, 0);
    send_nav(0, 0, 10000000, 1000000, 0, 1000, 0, 0, 0, 1, 0);
    send_nav(0, 0, 0, 0, -25736, -1000, 0, 0, 1000000, 1, 0);
    send_nav(0, 0, 0, 0, 12868, 0, 3000, 5, 7, 0, 0);
    send_nav(0, 0, 0, 0, -12868, 0, -3000, 5, 7, 1, 0);
    send_nav(0, 0, 0, 0, 25736, -3000, 1, 1, 1, 0, 0);
    send_nav(0, 0, 0, 0, -25736, -3000, -1, 1, 1, 0, 0);
    send_nav(-1000000000, -1000000000, 0, 0, 0, 1000000000, 1000000000, 0, 0, 0, 0);
    send_nav(1000000000, 1000000000, 0, 0, 0, -1000000000, -1000000000, 0, 0, 0, 0);
    send_nav(1000000000, -1000000000, 0, 0, 0, -1000000000, 1000000000, 0, 0, 0, 0);
    send_nav(0, 0, 0, 0, 0, 49000, 0, 0, 0, 0, 0);
    send_nav(0, 0, 0, 0, 0, 51000, 0, 0, 0, 0, 0);
    send_nav(0, 0, 0, 0, 0, 2000, 0, 0, 0, 0, 0);
    send_nav(0, 0, 0, 0, 4290, 2500, 0, 0, 0, 0, 0);
    send_nav(0, 0, 0, 0, 0, 1, 1, 0, 0, 0, 0);
    drain();
    // settings: reset, extremes, floor above ceiling, zero tolerance
    for (int phase = 0; phase < 8; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_GAIN, 65535); write_reg(REG_RADIUS, 100000);
          write_reg(REG_FLOOR, -5000); write_reg(REG_CEILING, 5000);
          write_reg(REG_SAFETY, 1000000000); write_reg(REG_TOLERANCE, 25736);
        end
        2: begin
          write_reg(REG_GAIN, 0); write_reg(REG_RADIUS, 0);
          write_reg(REG_FLOOR, 5000); write_reg(REG_CEILING, -5000);
          write_reg(REG_SAFETY, 0); write_reg(REG_TOLERANCE, 0);
        end
        3: begin
          write_reg(REG_GAIN, 16383); write_reg(REG_FLOOR, 200); write_reg(REG_CEILING, 100);
          write_reg(REG_SAFETY, 80000); write_reg(REG_TOLERANCE, 12000);
          write_reg(REG_RADIUS, 30000);
        end
        default: if (phase > 0) begin
          write_reg(REG_GAIN, $urandom_range(0, 65535));
          write_reg(REG_RADIUS, $urandom_range(0, 100000));
          write_reg(REG_FLOOR, longint'($urandom_range(0, 10000)) - 5000);
          write_reg(REG_CEILING, longint'($urandom_range(0, 10000)) - 5000);
          write_reg(REG_SAFETY, $urandom_range(0, 3) == 0 ? $urandom_range(0, 1000000000)
                                                           : $urandom_range(0, 200000));
          write_reg(REG_TOLERANCE, $urandom_range(0, 25736));
        end
      endcase
      for (int k = 0; k < 200; k++) random_nav(phase < 7);
      if (phase == 6) sink_calm = 1;
      drain();
    end
    if (fail_count == 0) begin
      $display("** anchor_station_keeping_control: PASSED **");
    end else begin
      $display("** anchor_station_keeping_control: FAILED **");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/ask_pkg.sv
rtl/ask_cordic_stage.sv
rtl/ask_post.sv
rtl/anchor_station_keeping_control.sv
sim/anchor_station_keeping_checker.sv
sim/testbench.sv
